>>> design/palette_fade_interpolator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the palette fade interpolator
// Same-cycle and next-cycle implication checks, reset disables both.
// ---------------------------------------------------------------------------
`ifndef PALETTE_FADE_INTERPOLATOR_ASSERT_SVH
`define PALETTE_FADE_INTERPOLATOR_ASSERT_SVH

// Antecedent implies consequent on the same edge
`define PFI_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the following edge
`define PFI_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pfi_pkg.sv
// ---------------------------------------------------------------------------
// pfi_pkg
// Shared codes, command and status types and the YUV packing function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfi_pkg;

  // Request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FADE = 2'd1;
  localparam logic [1:0] REQ_SET  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_COLOR = 2'd0;
  localparam logic [1:0] CFG_COLOR_SPAN  = 2'd1;
  localparam logic [1:0] CFG_NUM_STEPS   = 2'd2;

  // Configuration reset values
  localparam logic [7:0] FIRST_COLOR_RST = 8'd0;
  localparam logic [7:0] COLOR_SPAN_RST  = 8'd255;
  localparam logic [7:0] NUM_STEPS_RST   = 8'd16;

  // Quotient bits produced by the divider, one per cycle
  localparam int DIV_STEPS = 8;

  localparam logic [7:0] YUV_BIAS = 8'd128;

  typedef struct packed {
    logic capture;
    logic read;
    logic mul;
    logic div_step;
    logic write;
  } pfi_cmd_t;

  typedef struct packed {
    logic div_last;
  } pfi_status_t;

  // Y = sum/4, U = 128 + floor((r-b)/4), V = 128 + floor((2g-r-b)/8)
  function automatic logic [23:0] pack_yuv(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [9:0]         sum;
    logic signed [9:0]  du;
    logic signed [10:0] dv;
    logic [7:0]         y;
    logic [7:0]         u;
    logic [7:0]         v;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    y   = sum[9:2];
    du  = $signed({2'b00, r}) - $signed({2'b00, b});
    dv  = $signed({2'b00, g, 1'b0}) - $signed({3'b000, r}) - $signed({3'b000, b});
    u   = YUV_BIAS + 8'(du >>> 2);
    v   = YUV_BIAS + 8'(dv >>> 3);
    return {y, u, v};
  endfunction

endpackage

>>> design/pfi_if.sv
// ---------------------------------------------------------------------------
// pfi interfaces
// Request, result and configuration channels, valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfi_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] index;
  logic [7:0] fade_step;
  logic [7:0] red_a;
  logic [7:0] green_a;
  logic [7:0] blue_a;
  logic [7:0] red_b;
  logic [7:0] green_b;
  logic [7:0] blue_b;

  modport source (output valid, req_type, index, fade_step, red_a, green_a, blue_a,
                  red_b, green_b, blue_b, input ready);
  modport sink (input valid, req_type, index, fade_step, red_a, green_a, blue_a,
                red_b, green_b, blue_b, output ready);
endinterface

interface pfi_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  entry_index;
  logic [7:0]  cur_red;
  logic [7:0]  cur_green;
  logic [7:0]  cur_blue;
  logic [23:0] yuv_word;

  modport source (output valid, entry_index, cur_red, cur_green, cur_blue, yuv_word,
                  input ready);
  modport sink (input valid, entry_index, cur_red, cur_green, cur_blue, yuv_word,
                output ready);
endinterface

interface pfi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/pfi_ctrl.sv
// ---------------------------------------------------------------------------
// pfi_ctrl
// Sequencer: capture, palette read, multiply, divide, write back and output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pfi_pkg::pfi_cmd_t   cmd,
  input  pfi_pkg::pfi_status_t status
);
  import pfi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } state_t;

  state_t state;

  // Refuse words while reset is held
  assign in_ready = (state == ST_IDLE) && !rst;

  // Decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_ready && in_valid;
    cmd.read     = (state == ST_READ);
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.write    = (state == ST_WRITE) && (!out_valid || out_ready);
  end

  // Advance state, hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_READ;
        end
        ST_READ:  state <= ST_MUL;
        ST_MUL:   state <= ST_DIV;
        ST_DIV: begin
          if (status.div_last) state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (cmd.write) state <= ST_IDLE;
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/pfi_datapath.sv
// ---------------------------------------------------------------------------
// pfi_datapath
// Palette memories, configuration, per-channel multiply and restoring divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfi_datapath #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pfi_pkg::pfi_cmd_t    cmd,
  output pfi_pkg::pfi_status_t status,
  input  logic [1:0]           req_type,
  input  logic [7:0]           index,
  input  logic [7:0]           fade_step,
  input  logic [7:0]           red_a,
  input  logic [7:0]           green_a,
  input  logic [7:0]           blue_a,
  input  logic [7:0]           red_b,
  input  logic [7:0]           green_b,
  input  logic [7:0]           blue_b,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic [7:0]           entry_index,
  output logic [7:0]           cur_red,
  output logic [7:0]           cur_green,
  output logic [7:0]           cur_blue,
  output logic [23:0]          yuv_word
);
  import pfi_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = $clog2(DIV_STEPS);

  // Configuration
  logic [7:0] first_color;
  logic [7:0] color_span;
  logic [7:0] num_steps;

  // Captured word
  logic [1:0]      req;
  logic [7:0]      idx;
  logic [7:0]      step;
  logic [2:0][7:0] col_a;
  logic [2:0][7:0] col_b;

  // Palette storage; current colours read black until first written
  logic [2:0][7:0]        src_mem [PALETTE_ENTRIES];
  logic [2:0][7:0]        tgt_mem [PALETTE_ENTRIES];
  logic [2:0][7:0]        cur_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] cur_vld;

  logic [2:0][7:0] src_rd;
  logic [2:0][7:0] tgt_rd;
  logic [2:0][7:0] cur_rd;
  logic            vld_rd;

  // Divider state: remainder in the top byte, quotient shifts into the bottom
  logic [2:0][15:0] acc;
  logic [2:0]       neg;
  logic [CW-1:0]    div_cnt;

  logic [AW-1:0]   addr;
  logic            in_pal;
  logic [8:0]      span_end;
  logic [7:0]      last;
  logic            hit;
  logic            sat;
  logic            wr_cur;
  logic            wr_st;
  logic [2:0][7:0] mag;
  logic [2:0][9:0] trial;
  logic [2:0][7:0] fade_val;
  logic [2:0][7:0] old_col;
  logic [2:0][7:0] new_col;
  logic [2:0][7:0] res_col;

  assign addr   = idx[AW-1:0];
  assign in_pal = ({24'd0, idx} < 32'(PALETTE_ENTRIES));

  // Fade range end saturates at the last entry code
  assign span_end = {1'b0, first_color} + {1'b0, color_span};
  assign last     = span_end[8] ? 8'hFF : span_end[7:0];
  assign hit      = (idx >= first_color) && (idx <= last);
  assign sat      = (num_steps == 8'd0) || (step >= num_steps);

  assign wr_cur = in_pal && ((req == REQ_SET) || ((req == REQ_FADE) && hit));
  assign wr_st  = in_pal && (req == REQ_LOAD);

  assign status.div_last = (div_cnt == CW'(DIV_STEPS - 1));

  // Per-channel arithmetic
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c]      = (tgt_rd[c] < src_rd[c]) ? (src_rd[c] - tgt_rd[c])
                                            : (tgt_rd[c] - src_rd[c]);
      trial[c]    = {1'b0, acc[c][15:7]} - {2'b00, num_steps};
      fade_val[c] = sat    ? tgt_rd[c] :
                    neg[c] ? (src_rd[c] - acc[c][7:0]) : (src_rd[c] + acc[c][7:0]);
      old_col[c]  = vld_rd ? cur_rd[c] : 8'd0;
      if (req == REQ_SET) begin
        new_col[c] = col_a[c];
      end else if ((req == REQ_FADE) && hit) begin
        new_col[c] = fade_val[c];
      end else begin
        new_col[c] = old_col[c];
      end
      res_col[c]  = in_pal ? new_col[c] : 8'd0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_color <= FIRST_COLOR_RST;
      color_span  <= COLOR_SPAN_RST;
      num_steps   <= NUM_STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_COLOR: first_color <= cfg_data;
        CFG_COLOR_SPAN:  color_span  <= cfg_data;
        CFG_NUM_STEPS:   num_steps   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req   <= req_type;
      idx   <= index;
      step  <= fade_step;
      col_a <= {red_a, green_a, blue_a};
      col_b <= {red_b, green_b, blue_b};
    end
  end

  // Palette memories: registered read, write back at the end of the item
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      src_rd <= src_mem[addr];
      tgt_rd <= tgt_mem[addr];
      cur_rd <= cur_mem[addr];
    end
    if (cmd.write && wr_st) begin
      src_mem[addr] <= col_a;
      tgt_mem[addr] <= col_b;
    end
    if (cmd.write && wr_cur) begin
      cur_mem[addr] <= new_col;
    end
  end

  // Valid bits for current colours
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= '0;
    end else if (cmd.write && wr_cur) begin
      cur_vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      vld_rd <= cur_vld[addr];
    end
  end

  // Multiply then divide by num_steps, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.mul) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.mul) begin
        neg[c] <= (tgt_rd[c] < src_rd[c]);
        acc[c] <= {8'd0, mag[c]} * {8'd0, step};
      end else if (cmd.div_step) begin
        if (!trial[c][9]) begin
          acc[c] <= {trial[c][7:0], acc[c][6:0], 1'b1};
        end else begin
          acc[c] <= {acc[c][14:0], 1'b0};
        end
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      entry_index <= idx;
      cur_red     <= res_col[2];
      cur_green   <= res_col[1];
      cur_blue    <= res_col[0];
      yuv_word    <= pack_yuv(res_col[2], res_col[1], res_col[0]);
    end
  end

endmodule

>>> design/palette_fade_interpolator.sv
// ---------------------------------------------------------------------------
// palette_fade_interpolator
// Palette RAM with per-entry linear fade between stored source and target.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  item      in    valid/ready    req_type, index, fade_step, red/green/blue a and b
//  result    out   valid/ready    entry_index, cur_red/green/blue, yuv_word
//  cfg       in    valid/ready    index (register), data; ready out of reset
//
//  Each word passes through capture, memory read, multiply, eight divider
//  steps (one quotient bit per cycle for all three channels) and write back.
//  The result register frees the input side: the next word is taken while
//  a result waits, and write back stalls only while that result is untaken.
//  Reset restores the configuration reset values and clears the current-colour valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_fade_interpolator_assert.svh"

module palette_fade_interpolator #(
  parameter int PALETTE_ENTRIES = 256
) (
  input logic          clk,
  input logic          rst,
  pfi_item_if.sink     item,
  pfi_result_if.source result,
  pfi_cfg_if.sink      cfg
);
  import pfi_pkg::*;

  pfi_cmd_t    cmd;
  pfi_status_t status;

  // Take register writes whenever out of reset
  assign cfg.ready = !rst;

  pfi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  pfi_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .req_type    (item.req_type),
    .index       (item.index),
    .fade_step   (item.fade_step),
    .red_a       (item.red_a),
    .green_a     (item.green_a),
    .blue_a      (item.blue_a),
    .red_b       (item.red_b),
    .green_b     (item.green_b),
    .blue_b      (item.blue_b),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .entry_index (result.entry_index),
    .cur_red     (result.cur_red),
    .cur_green   (result.cur_green),
    .cur_blue    (result.cur_blue),
    .yuv_word    (result.yuv_word)
  );

  // One word in flight: acceptance leaves the idle state
  `PFI_ASSERT_NEXT(a_one_word, clk, rst, item.valid && item.ready, !item.ready,
                   "second word taken while busy")
  // Ready drops only because a word was taken
  `PFI_ASSERT_SAME(a_ready_fall, clk, rst, $fell(item.ready), $past(item.valid),
                   "ready fell without a word")
  // A new result comes only from write back, which returns to idle
  `PFI_ASSERT_SAME(a_result_idle, clk, rst, $rose(result.valid), item.ready,
                   "result raised while busy")

endmodule

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the palette fade interpolator. A behavioural copy
// of the palette (source, target and current colours plus the three fade
// registers) predicts every report. Reports are checked in order against
// that prediction. Directed words cover loads, fades, direct sets, idle
// requests, the fade window and the step-count extremes. A long random run
// then mixes fade frames with random traffic under several settings, with
// random gaps on the request side and random stalls on the report side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pfi_pkg::*;

  // Request code with no action; the block only reports the entry
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int WORD_TARGET = 1900;
  localparam int PHASE_WORDS = 240;
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0]  entry_index;
    logic [7:0]  cur_red;
    logic [7:0]  cur_green;
    logic [7:0]  cur_blue;
    logic [23:0] yuv_word;
  } colour_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfi_item_if   item_ch();
  pfi_result_if result_ch();
  pfi_cfg_if    cfg_ch();

  palette_fade_interpolator DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Palette copy: colours packed red 23:16, green 15:8, blue 7:0
  logic [23:0]    source_mem [256];
  logic [23:0]    target_mem [256];
  logic [23:0]    current_mem [256];
  bit             loaded [256];
  logic [7:0]     first_cfg;
  logic [7:0]     span_cfg;
  logic [7:0]     steps_cfg;

  colour_report_t expected_reports [$];
  colour_report_t want;

  int error_count;
  int words_sent;
  int reports_seen;
  int settings_count;
  int cycle_count;
  int rx_hold;
  bit no_idle;

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  function automatic int window_last();
    int last;
    last = int'(first_cfg) + int'(span_cfg);
    if (last > 255) begin
      last = 255;
    end
    return last;
  endfunction

  function automatic logic [7:0] fade_channel(input logic [7:0] from, input logic [7:0] to,
                                              input logic [7:0] step);
    int diff;
    if (steps_cfg == 8'd0 || step >= steps_cfg) begin
      return to;
    end
    diff = int'(to) - int'(from);
    return 8'(int'(from) + (diff * int'(step)) / int'(steps_cfg));
  endfunction

  // Y = sum/4, U and V biased by 128, shifts floor toward minus infinity
  function automatic logic [23:0] yuv_of(input logic [23:0] col);
    int r;
    int g;
    int b;
    int y;
    int u;
    int v;
    r = int'(col[23:16]);
    g = int'(col[15:8]);
    b = int'(col[7:0]);
    y = (r + g + b) >>> 2;
    u = 128 + ((r - b) >>> 2);
    v = 128 + ((2 * g - r - b) >>> 3);
    return {8'(y), 8'(u), 8'(v)};
  endfunction

  // Apply one accepted word to the palette copy and queue its report
  function automatic void apply_palette_word(input logic [1:0] req, input logic [7:0] idx,
                                             input logic [7:0] step, input logic [23:0] col_a,
                                             input logic [23:0] col_b);
    colour_report_t rep;
    logic [23:0]    src;
    logic [23:0]    tgt;
    src = source_mem[idx];
    tgt = target_mem[idx];
    case (req)
      REQ_LOAD: begin
        source_mem[idx] = col_a;
        target_mem[idx] = col_b;
        loaded[idx] = 1'b1;
      end
      REQ_FADE: begin
        if (idx >= first_cfg && int'(idx) <= window_last()) begin
          current_mem[idx] = {fade_channel(src[23:16], tgt[23:16], step),
                              fade_channel(src[15:8], tgt[15:8], step),
                              fade_channel(src[7:0], tgt[7:0], step)};
        end
      end
      REQ_SET: begin
        current_mem[idx] = col_a;
      end
      default: begin
      end
    endcase
    rep.entry_index = idx;
    rep.cur_red     = current_mem[idx][23:16];
    rep.cur_green   = current_mem[idx][15:8];
    rep.cur_blue    = current_mem[idx][7:0];
    rep.yuv_word    = yuv_of(current_mem[idx]);
    expected_reports.push_back(rep);
  endfunction

  // ------------------------------------------------------------------
  // Random helpers
  // ------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return idle_length();
  endfunction

  function automatic logic [23:0] random_colour();
    return 24'($urandom);
  endfunction

  // Favour entries inside the fade window
  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 99) < 60) begin
      return 8'($urandom_range(int'(first_cfg), window_last()));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Favour steps up to the step count, with some past it
  function automatic logic [7:0] pick_step();
    if (steps_cfg == 8'd0 || $urandom_range(0, 99) < 30) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, int'(steps_cfg)));
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  // Send one request word; valid stays high when no gap follows
  task automatic send_word(input logic [1:0] req, input logic [7:0] idx, input logic [7:0] step,
                           input logic [23:0] col_a, input logic [23:0] col_b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.req_type  <= req;
    item_ch.index     <= idx;
    item_ch.fade_step <= step;
    item_ch.red_a     <= col_a[23:16];
    item_ch.green_a   <= col_a[15:8];
    item_ch.blue_a    <= col_a[7:0];
    item_ch.red_b     <= col_b[23:16];
    item_ch.green_b   <= col_b[15:8];
    item_ch.blue_b    <= col_b[7:0];
    do @(posedge clk); while (!item_ch.ready);
    apply_palette_word(req, idx, step, col_a, col_b);
    words_sent++;
  endtask

  // Hold the request side until every queued report has come back
  task automatic drain_reports();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic cfg_word(input logic [1:0] reg_idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (reg_idx)
      CFG_FIRST_COLOR: first_cfg = value;
      CFG_COLOR_SPAN:  span_cfg  = value;
      CFG_NUM_STEPS:   steps_cfg = value;
      default: begin
      end
    endcase
  endtask

  // Write all three fade registers with the block idle
  task automatic write_settings(input logic [7:0] first, input logic [7:0] span,
                                input logic [7:0] steps);
    drain_reports();
    cfg_word(CFG_FIRST_COLOR, first);
    cfg_word(CFG_COLOR_SPAN, span);
    cfg_word(CFG_NUM_STEPS, steps);
    cfg_ch.valid <= 1'b0;
    settings_count++;
  endtask

  // ------------------------------------------------------------------
  // Report side: random stalls, in-order check
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 25) begin
        rx_hold = idle_length();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("report for entry %0d with nothing expected", result_ch.entry_index);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        if (result_ch.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index, result_ch.entry_index);
          error_count++;
        end
        if (result_ch.cur_red !== want.cur_red) begin
          $error("cur_red: expected %0d, got %0d", want.cur_red, result_ch.cur_red);
          error_count++;
        end
        if (result_ch.cur_green !== want.cur_green) begin
          $error("cur_green: expected %0d, got %0d", want.cur_green, result_ch.cur_green);
          error_count++;
        end
        if (result_ch.cur_blue !== want.cur_blue) begin
          $error("cur_blue: expected %0d, got %0d", want.cur_blue, result_ch.cur_blue);
          error_count++;
        end
        if (result_ch.yuv_word !== want.yuv_word) begin
          $error("yuv_word: expected %06h, got %06h", want.yuv_word, result_ch.yuv_word);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Loads and idle requests report the untouched black entries
  task automatic test_load_and_report();
    send_word(REQ_LOAD, 8'd0, 8'd0, 24'h000000, 24'hFFFFFF);
    send_word(REQ_LOAD, 8'd255, 8'd255, 24'hFFFFFF, 24'h000000);
    send_word(REQ_NONE, 8'd100, 8'd7, 24'h123456, 24'h654321);
  endtask

  // Reset settings: full window, sixteen steps, saturation at the end
  task automatic test_fade_default();
    send_word(REQ_FADE, 8'd0, 8'd0, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd0, 8'd8, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd255, 8'd8, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd0, 8'd16, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd255, 8'd255, 24'h0, 24'h0);
  endtask

  // Direct sets at the colour extremes exercise the YUV packing
  task automatic test_direct_set_yuv();
    send_word(REQ_SET, 8'd40, 8'd0, 24'hFF0000, 24'hFFFFFF);
    send_word(REQ_SET, 8'd40, 8'd0, 24'h0000FF, 24'h000000);
    send_word(REQ_SET, 8'd40, 8'd0, 24'h00FF00, 24'h000000);
    send_word(REQ_SET, 8'd40, 8'd0, 24'hFFFFFF, 24'h000000);
  endtask

  // Entries just outside the window stay put; the window end clamps at 255
  task automatic test_fade_window();
    write_settings(8'd10, 8'd5, 8'd16);
    send_word(REQ_LOAD, 8'd9, 8'd0, 24'h102030, 24'hF0E0D0);
    send_word(REQ_LOAD, 8'd12, 8'd0, 24'hF0E0D0, 24'h102030);
    send_word(REQ_LOAD, 8'd16, 8'd0, 24'h808080, 24'h000000);
    send_word(REQ_FADE, 8'd9, 8'd4, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd12, 8'd4, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd16, 8'd4, 24'h0, 24'h0);
    write_settings(8'd250, 8'd255, 8'd16);
    send_word(REQ_FADE, 8'd255, 8'd3, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd0, 8'd3, 24'h0, 24'h0);
  endtask

  // Zero steps jumps to target; one and 255 steps at their edges
  task automatic test_step_count_extremes();
    write_settings(8'd0, 8'd255, 8'd0);
    send_word(REQ_FADE, 8'd12, 8'd0, 24'h0, 24'h0);
    write_settings(8'd0, 8'd255, 8'd1);
    send_word(REQ_FADE, 8'd12, 8'd0, 24'h0, 24'h0);
    write_settings(8'd0, 8'd255, 8'd255);
    send_word(REQ_FADE, 8'd0, 8'd254, 24'h0, 24'h0);
    send_word(REQ_FADE, 8'd255, 8'd254, 24'h0, 24'h0);
  endtask

  task automatic random_word();
    int         roll;
    logic [1:0] req;
    logic [7:0] idx;
    roll = $urandom_range(0, 99);
    idx  = pick_index();
    if (roll < 25) begin
      req = REQ_LOAD;
    end else if (roll < 70) begin
      req = REQ_FADE;
    end else if (roll < 90) begin
      req = REQ_SET;
    end else begin
      req = REQ_NONE;
    end
    // Fade only entries whose colours were loaded
    if (req == REQ_FADE && !loaded[idx]) begin
      req = REQ_LOAD;
    end
    send_word(req, idx, pick_step(), random_colour(), random_colour());
  endtask

  // One frame: the same step across up to eight loaded entries of the window
  task automatic fade_frame();
    int         last;
    int         e;
    int         hits;
    logic [7:0] step;
    last = window_last();
    step = pick_step();
    hits = 0;
    for (e = int'(first_cfg); e <= last && hits < 8; e++) begin
      if (loaded[e]) begin
        send_word(REQ_FADE, 8'(e), step, random_colour(), random_colour());
        hits++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int         phase;
    int         n;
    logic [7:0] first;
    logic [7:0] span;
    logic [7:0] steps;
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 3))
        0:       first = 8'd0;
        1:       first = 8'd255;
        default: first = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       span = 8'd0;
        1:       span = 8'd255;
        2:       span = 8'($urandom_range(0, 31));
        default: span = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       steps = 8'd0;
        1:       steps = 8'd1;
        2:       steps = 8'd255;
        default: steps = 8'($urandom_range(2, 32));
      endcase
      write_settings(first, span, steps);
      // One phase runs with no gaps on either side
      no_idle = (phase == 2);
      for (n = 0; n < PHASE_WORDS && words_sent < WORD_TARGET; n++) begin
        if (n == PHASE_WORDS / 2) begin
          drain_reports();
        end
        if ($urandom_range(0, 19) == 0) begin
          fade_frame();
        end else begin
          random_word();
        end
      end
      no_idle = 1'b0;
      phase++;
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    for (int e = 0; e < 256; e++) begin
      current_mem[e] = 24'h0;
      source_mem[e]  = 24'h0;
      target_mem[e]  = 24'h0;
      loaded[e]      = 1'b0;
    end
    first_cfg      = FIRST_COLOR_RST;
    span_cfg       = COLOR_SPAN_RST;
    steps_cfg      = NUM_STEPS_RST;
    error_count    = 0;
    words_sent     = 0;
    reports_seen   = 0;
    settings_count = 0;
    cycle_count    = 0;
    rx_hold        = 0;
    no_idle        = 1'b0;

    item_ch.valid     = 1'b0;
    item_ch.req_type  = REQ_LOAD;
    item_ch.index     = 8'd0;
    item_ch.fade_step = 8'd0;
    item_ch.red_a     = 8'd0;
    item_ch.green_a   = 8'd0;
    item_ch.blue_a    = 8'd0;
    item_ch.red_b     = 8'd0;
    item_ch.green_b   = 8'd0;
    item_ch.blue_b    = 8'd0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FIRST_COLOR;
    cfg_ch.data       = 8'd0;
    result_ch.ready   = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_load_and_report();
    test_fade_default();
    test_direct_set_yuv();
    test_fade_window();
    test_step_count_extremes();
    test_random_traffic();

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d words sent, %0d reports checked, %0d register settings",
             words_sent, reports_seen, settings_count);
    $display("tb_top: loads, fades, direct sets and idle requests under gaps and stalls");
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/pfi_pkg.sv
design/pfi_if.sv
design/pfi_ctrl.sv
design/pfi_datapath.sv
design/palette_fade_interpolator.sv
test/tb_top.sv
